/* hdl/cpyr_pkg.sv */
package cpyr_pkg;

    // Frame size limits; larger register values saturate here
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // Widths of the frame-size registers, position counters and address
    localparam int DIM_W  = 13;
    localparam int CNT_W  = 12;
    localparam int ADDR_W = 24;

    // YUV to RGB fixed-point constants
    localparam int U_SCALE   = 14343;
    localparam int U_OFFSET  = 1828717;
    localparam int V_SCALE   = 20231;
    localparam int V_OFFSET  = 2579497;
    localparam int K_RV      = 290;
    localparam int K_GU      = 100;
    localparam int K_GV      = 148;
    localparam int K_BU      = 518;
    localparam int FRAC_BITS = 22;

    typedef enum logic [2:0] {
        FMT_UYV444 = 3'd0,
        FMT_UYVY   = 3'd1,
        FMT_YUYV   = 3'd2,
        FMT_Y411   = 3'd3,
        FMT_GRAY   = 3'd4,
        FMT_BGR3   = 3'd5,
        FMT_BGR4   = 3'd6,
        FMT_RGB4   = 3'd7
    } pix_fmt_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_PIXEL_FORMAT = 2'd0,
        REG_FRAME_WIDTH  = 2'd1,
        REG_FRAME_HEIGHT = 2'd2,
        REG_UNUSED       = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_SELECT = 3'd1,
        ST_MULT   = 3'd2,
        ST_SUM    = 3'd3,
        ST_EMIT   = 3'd4
    } ctl_state_t;

    // Effective configuration, shared by controller and datapath
    typedef struct packed {
        pix_fmt_t           fmt;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic               clear;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       accept;
        logic [2:0] phase;
        logic       pix_idx;
        logic       select;
        logic       mult;
        logic       sum;
        logic       emit;
        logic       last;
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // Bytes per group for each format
    function automatic logic [2:0] group_len(input pix_fmt_t fmt);
        logic [2:0] len;
        unique case (fmt)
            FMT_UYV444: len = 3'd3;
            FMT_UYVY:   len = 3'd4;
            FMT_YUYV:   len = 3'd4;
            FMT_Y411:   len = 3'd6;
            FMT_GRAY:   len = 3'd1;
            FMT_BGR3:   len = 3'd3;
            FMT_BGR4:   len = 3'd4;
            FMT_RGB4:   len = 3'd4;
            default:    len = 3'd1;
        endcase
        return len;
    endfunction

    // Pixels produced by the byte at a given group phase
    function automatic logic [1:0] pix_count(input pix_fmt_t fmt, input logic [2:0] ph);
        logic [1:0] n;
        unique case (fmt)
            FMT_UYV444: n = (ph == 3'd2) ? 2'd1 : 2'd0;
            FMT_UYVY:   n = (ph == 3'd3) ? 2'd2 : 2'd0;
            FMT_YUYV:   n = (ph == 3'd3) ? 2'd2 : 2'd0;
            FMT_Y411:   n = (ph == 3'd3) ? 2'd2 : ((ph >= 3'd4) ? 2'd1 : 2'd0);
            FMT_GRAY:   n = 2'd1;
            FMT_BGR3:   n = (ph == 3'd2) ? 2'd1 : 2'd0;
            FMT_BGR4:   n = (ph == 3'd3) ? 2'd1 : 2'd0;
            FMT_RGB4:   n = (ph == 3'd3) ? 2'd1 : 2'd0;
            default:    n = 2'd0;
        endcase
        return n;
    endfunction

    // Saturate a small signed value to 0..255
    function automatic logic [7:0] clamp8(input logic signed [11:0] x);
        logic [7:0] c;
        if (x < 0)
            c = 8'd0;
        else if (x > 12'sd255)
            c = 8'd255;
        else
            c = x[7:0];
        return c;
    endfunction

endpackage

/* hdl/cpyr_ctrl.sv */
module cpyr_ctrl
    import cpyr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output ctl_cmd_t   cmd
);

    ctl_state_t state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic [2:0] byte_ph_reg, byte_ph_next;
    logic [1:0] npix_reg, npix_next;
    logic       pix_idx_reg, pix_idx_next;

    logic [2:0] glen;
    logic [2:0] eff_ph;
    logic [2:0] ph_inc;
    logic [1:0] npix_now;

    // Group position of the incoming byte
    always_comb
    begin
        glen     = group_len(cfg.fmt);
        eff_ph   = (phase_reg >= glen) ? 3'd0 : phase_reg;
        ph_inc   = eff_ph + 3'd1;
        npix_now = pix_count(cfg.fmt, eff_ph);
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        byte_ph_next = byte_ph_reg;
        npix_next    = npix_reg;
        pix_idx_next = pix_idx_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.phase    = byte_ph_reg;
        cmd.pix_idx  = pix_idx_reg;
        cmd.last     = (npix_reg == 2'd1) || pix_idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                cmd.phase = eff_ph;
                if (s_tvalid)
                begin
                    cmd.accept   = 1'b1;
                    byte_ph_next = eff_ph;
                    phase_next   = (ph_inc >= glen) ? 3'd0 : ph_inc;
                    npix_next    = npix_now;
                    pix_idx_next = 1'b0;
                    if (npix_now != 2'd0)
                        state_next = ST_SELECT;
                end
            end
            ST_SELECT:
            begin
                cmd.select = 1'b1;
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (cmd.last)
                        state_next = ST_IDLE;
                    else
                    begin
                        pix_idx_next = 1'b1;
                        state_next   = ST_SELECT;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A write to register index 0-2 restarts the group
        if (cfg.clear)
            phase_next = 3'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= 3'd0;
            byte_ph_reg <= 3'd0;
            npix_reg    <= 2'd0;
            pix_idx_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            byte_ph_reg <= byte_ph_next;
            npix_reg    <= npix_next;
            pix_idx_reg <= pix_idx_next;
        end
    end

endmodule

/* hdl/cpyr_datapath.sv */
module cpyr_datapath
    import cpyr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  ctl_cmd_t    cmd,
    input  logic [7:0]  s_tdata,
    output dp_status_t  status,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    // Group byte store
    logic [7:0] byte_reg;
    logic [7:0] held_u_reg, held_v_reg, luma_a_reg, luma_b_reg;

    // Operand selection and conversion stages
    logic [7:0]              op0_reg, op1_reg, op2_reg;
    logic                    is_yuv_reg, single_reg;
    logic signed [24:0]      u2_reg, v2_reg;
    logic [ADDR_W-1:0]       base_reg;
    logic signed [33:0]      pr_reg, pgu_reg, pgv_reg, pb_reg;
    logic [7:0]              res_r_reg, res_g_reg, res_b_reg;
    logic [ADDR_W-1:0]       addr_reg;

    // Frame position
    logic [CNT_W-1:0]        col_reg, row_reg;

    // Output register
    logic                    out_valid_reg;
    logic [47:0]             out_data_reg;
    logic [1:0]              out_user_reg;
    logic                    out_last_reg;

    logic [7:0]              sel_y, sel_u, sel_v;
    logic                    sel_yuv, sel_single;
    logic [21:0]             uprod;
    logic [22:0]             vprod;
    logic signed [24:0]      u2_next, v2_next;
    logic [CNT_W-1:0]        h_last, w_last, row_sel;
    logic [2*DIM_W-2:0]      base_full;
    logic signed [34:0]      g_sum;
    logic signed [11:0]      r_off, g_off, b_off, y_ext;
    logic signed [11:0]      r_val, g_val, b_val;
    logic                    eof;

    // Pick the three bytes for the current pixel
    always_comb
    begin
        sel_y      = byte_reg;
        sel_u      = held_u_reg;
        sel_v      = held_v_reg;
        sel_yuv    = 1'b1;
        sel_single = 1'b0;
        unique case (cfg.fmt)
            FMT_UYV444:
            begin
                sel_y = luma_a_reg;
                sel_v = byte_reg;
            end
            FMT_UYVY:
            begin
                sel_y = cmd.pix_idx ? byte_reg : luma_a_reg;
            end
            FMT_YUYV:
            begin
                sel_y = cmd.pix_idx ? luma_b_reg : luma_a_reg;
                sel_v = byte_reg;
            end
            FMT_Y411:
            begin
                if (cmd.phase == 3'd3)
                    sel_y = cmd.pix_idx ? luma_b_reg : luma_a_reg;
                else
                    sel_y = byte_reg;
            end
            FMT_GRAY:
            begin
                sel_y      = byte_reg;
                sel_u      = 8'd0;
                sel_v      = 8'd0;
                sel_yuv    = 1'b0;
                sel_single = 1'b1;
            end
            FMT_BGR3:
            begin
                sel_y   = byte_reg;
                sel_u   = held_v_reg;
                sel_v   = held_u_reg;
                sel_yuv = 1'b0;
            end
            FMT_BGR4:
            begin
                sel_y   = luma_a_reg;
                sel_u   = held_v_reg;
                sel_v   = held_u_reg;
                sel_yuv = 1'b0;
            end
            FMT_RGB4:
            begin
                sel_y   = held_u_reg;
                sel_u   = held_v_reg;
                sel_v   = luma_a_reg;
                sel_yuv = 1'b0;
            end
            default:
            begin
                sel_yuv = 1'b0;
            end
        endcase
    end

    // Chroma offsets and row base address
    always_comb
    begin
        uprod   = 22'(sel_u) * 22'(U_SCALE);
        vprod   = 23'(sel_v) * 23'(V_SCALE);
        u2_next = $signed({3'b000, uprod}) - 25'(U_OFFSET);
        v2_next = $signed({2'b00, vprod}) - 25'(V_OFFSET);
        h_last  = CNT_W'(cfg.height - 13'd1);
        w_last  = CNT_W'(cfg.width - 13'd1);
        row_sel = (cfg.fmt == FMT_UYVY) ? (h_last - row_reg) : row_reg;
        base_full = (2*DIM_W-1)'(row_sel) * (2*DIM_W-1)'(cfg.width);
    end

    // Floor shift, add luma, saturate
    always_comb
    begin
        g_sum = 35'(pgu_reg) + 35'(pgv_reg);
        r_off = 12'(pr_reg >>> FRAC_BITS);
        g_off = 12'(g_sum >>> FRAC_BITS);
        b_off = 12'(pb_reg >>> FRAC_BITS);
        y_ext = $signed({4'b0000, op0_reg});
        r_val = y_ext + r_off;
        g_val = y_ext - g_off;
        b_val = y_ext + b_off;
        eof   = (row_reg == h_last) && (col_reg == w_last);
    end

    // Store bytes of the group as they arrive
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg   <= 8'd0;
            held_u_reg <= 8'd0;
            held_v_reg <= 8'd0;
            luma_a_reg <= 8'd0;
            luma_b_reg <= 8'd0;
        end
        else if (cmd.accept)
        begin
            byte_reg <= s_tdata;
            unique case (cfg.fmt)
                FMT_UYV444, FMT_UYVY, FMT_Y411:
                begin
                    if (cmd.phase == 3'd0)
                        held_u_reg <= s_tdata;
                    else if (cmd.phase == 3'd1)
                        luma_a_reg <= s_tdata;
                    else if (cmd.phase == 3'd2)
                    begin
                        if (cfg.fmt == FMT_UYVY)
                            held_v_reg <= s_tdata;
                        else if (cfg.fmt == FMT_Y411)
                            luma_b_reg <= s_tdata;
                    end
                    else if (cmd.phase == 3'd3 && cfg.fmt == FMT_Y411)
                        held_v_reg <= s_tdata;
                end
                FMT_YUYV:
                begin
                    if (cmd.phase == 3'd0)
                        luma_a_reg <= s_tdata;
                    else if (cmd.phase == 3'd1)
                        held_u_reg <= s_tdata;
                    else if (cmd.phase == 3'd2)
                        luma_b_reg <= s_tdata;
                end
                FMT_BGR3, FMT_BGR4, FMT_RGB4:
                begin
                    if (cmd.phase == 3'd0)
                        held_u_reg <= s_tdata;
                    else if (cmd.phase == 3'd1)
                        held_v_reg <= s_tdata;
                    else if (cmd.phase == 3'd2 && cfg.fmt != FMT_BGR3)
                        luma_a_reg <= s_tdata;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Conversion stages
    always_ff @(posedge clk)
    begin
        if (cmd.select)
        begin
            op0_reg    <= sel_y;
            op1_reg    <= sel_u;
            op2_reg    <= sel_v;
            is_yuv_reg <= sel_yuv;
            single_reg <= sel_single;
            u2_reg     <= u2_next;
            v2_reg     <= v2_next;
            base_reg   <= base_full[ADDR_W-1:0];
        end
        if (cmd.mult)
        begin
            pr_reg  <= 34'(v2_reg) * 34'(K_RV);
            pgu_reg <= 34'(u2_reg) * 34'(K_GU);
            pgv_reg <= 34'(v2_reg) * 34'(K_GV);
            pb_reg  <= 34'(u2_reg) * 34'(K_BU);
        end
        if (cmd.sum)
        begin
            res_r_reg <= is_yuv_reg ? clamp8(r_val) : op0_reg;
            res_g_reg <= is_yuv_reg ? clamp8(g_val) : op1_reg;
            res_b_reg <= is_yuv_reg ? clamp8(b_val) : op2_reg;
            addr_reg  <= base_reg + ADDR_W'(col_reg);
        end
    end

    // Frame position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg.clear)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.emit)
        begin
            if (eof)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (col_reg == w_last)
            begin
                col_reg <= '0;
                row_reg <= row_reg + 1'b1;
            end
            else
                col_reg <= col_reg + 1'b1;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= {addr_reg, res_b_reg, res_g_reg, res_r_reg};
            out_user_reg <= {cmd.last, single_reg};
            out_last_reg <= eof;
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* hdl/camera_pixel_unpack_yuv_to_rgb_top.sv */
// Camera byte unpacker with YUV to RGB conversion.
//
// Slave stream: one raw camera byte per item on s_tdata. The pixel format and
// frame size come from the write port (cfg_we, cfg_index, cfg_data); writes
// to index 0-2 restart byte group and frame position. Write only while idle.
// Master stream: one pixel per item; tdata holds red, green, blue and the
// 24-bit frame address, tuser holds single_plane and last_in_run, tlast marks
// the last pixel of a frame.
// Sequence: a byte that completes no pixel is taken while staying in idle. A
// byte that yields pixels sends each pixel through select, multiply, sum and
// output load, then returns to idle before the next byte is taken. The first
// pixel is valid once its byte has passed these steps. The per-pixel sequence
// through the shared multiply and sum stages sets the byte rate.
// A finished pixel sits in the output register; the next byte is accepted
// while it waits. If the receiver stalls, the sequencer holds in its output
// step until the register frees, and no input is taken meanwhile.
// Reset (rst_n low, asynchronous): format UYV444, 640 x 480, group and frame
// position cleared, output empty.
module camera_pixel_unpack_yuv_to_rgb_top
    import cpyr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] raw_byte
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [7:0] red, [15:8] green, [23:16] blue,
                                    // [47:24] pixel_address
    output logic [1:0]  m_tuser,    // [0] single_plane, [1] last_in_run
    output logic        m_tlast     // end_of_frame
);

    pix_fmt_t         fmt_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    cfg_t       cfg;
    ctl_cmd_t   cmd;
    dp_status_t status;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= FMT_UYV444;
            width_reg  <= 13'd640;
            height_reg <= 13'd480;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_PIXEL_FORMAT)
                fmt_reg <= pix_fmt_t'(cfg_data[2:0]);
            else if (cfg_index == REG_FRAME_WIDTH)
                width_reg <= cfg_data;
            else if (cfg_index == REG_FRAME_HEIGHT)
                height_reg <= cfg_data;
        end
    end

    // Saturated frame size and restart strobe
    always_comb
    begin
        cfg.fmt = fmt_reg;
        if (width_reg == '0)
            cfg.width = DIM_W'(1);
        else if (width_reg > DIM_W'(MAX_WIDTH))
            cfg.width = DIM_W'(MAX_WIDTH);
        else
            cfg.width = width_reg;
        if (height_reg == '0)
            cfg.height = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_HEIGHT))
            cfg.height = DIM_W'(MAX_HEIGHT);
        else
            cfg.height = height_reg;
        cfg.clear = cfg_we && (cfg_index != REG_UNUSED);
    end

    cpyr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cpyr_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* hdl/cpyr_checker.sv */
module cpyr_checker
    import cpyr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled pixel stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("pixel dropped while stalled");

    // A stalled pixel keeps its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("pixel changed while stalled");

    // Gray pixels carry only the red plane
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[15:8] == 8'd0 && m_tdata[23:16] == 8'd0)
        else $error("gray pixel with green or blue data");

    // A gray byte yields exactly one pixel, so it closes the run
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tuser[1])
        else $error("gray pixel not last of its byte");

    // Conversion runs through registered steps: no pixel appears right after a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("pixel appeared too early after byte");

endmodule

bind camera_pixel_unpack_yuv_to_rgb_top cpyr_checker u_cpyr_checker (.*);
